// ----- hdl/rv64d_pkg.sv -----
// Package for the RV64 instruction decoder: operation codes, opcodes, field helpers.
// No dependencies.
`default_nettype none
package rv64d_pkg;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_AMO    = 7'h2f;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP32   = 7'h3b;
	localparam logic [6:0] OPC_FLOAD  = 7'h07;
	localparam logic [6:0] OPC_FSTORE = 7'h27;
	localparam logic [6:0] OPC_FP     = 7'h53;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;

	localparam logic [31:0] WORD_ECALL  = 32'h00000073;
	localparam logic [31:0] WORD_EBREAK = 32'h00100073;

	localparam logic [7:0] OP_UNKNOWN = 8'd0;
	localparam logic [7:0] OP_LUI     = 8'd1;
	localparam logic [7:0] OP_AUIPC   = 8'd2;
	localparam logic [7:0] OP_JAL     = 8'd3;
	localparam logic [7:0] OP_JALR    = 8'd4;
	localparam logic [7:0] OP_BEQ     = 8'd5;
	localparam logic [7:0] OP_LB      = 8'd11;
	localparam logic [7:0] OP_SB      = 8'd18;
	localparam logic [7:0] OP_AMOADD_W = 8'd22;
	localparam logic [7:0] OP_ADDI    = 8'd28;
	localparam logic [7:0] OP_SRAI    = 8'd34;
	localparam logic [7:0] OP_ADDIW   = 8'd37;
	localparam logic [7:0] OP_SLLIW   = 8'd38;
	localparam logic [7:0] OP_SRLIW   = 8'd39;
	localparam logic [7:0] OP_SRAIW   = 8'd40;
	localparam logic [7:0] OP_ADD     = 8'd41;
	localparam logic [7:0] OP_ADDW    = 8'd59;
	localparam logic [7:0] OP_FLW     = 8'd77;
	localparam logic [7:0] OP_FSW     = 8'd79;
	localparam logic [7:0] OP_FADD_S  = 8'd81;
	localparam logic [7:0] OP_FADD_D  = 8'd104;
	localparam logic [7:0] OP_FCVT_S_D = 8'd127;
	localparam logic [7:0] OP_FCVT_D_S = 8'd128;
	localparam logic [7:0] OP_ECALL   = 8'd129;
	localparam logic [7:0] OP_EBREAK  = 8'd130;
	localparam logic [7:0] OP_FENCE   = 8'd131;

	typedef enum logic [2:0] {
		IMM_NONE, IMM_I, IMM_S, IMM_B, IMM_J, IMM_U, IMM_SH6, IMM_SH5
	} imm_kind_t;

	typedef struct packed {
		logic [7:0] op_code;
		imm_kind_t  imm_kind;
		logic       has_target;
		logic [1:0] ordering;
	} dec_ctl_t;

	function automatic logic [7:0] opimm_code(input logic [2:0] f3);
		logic [7:0] r;
		case (f3)
			3'd0: r = 8'd28;
			3'd1: r = 8'd29;
			3'd2: r = 8'd30;
			3'd3: r = 8'd31;
			3'd4: r = 8'd32;
			3'd5: r = 8'd33;
			3'd6: r = 8'd35;
			default: r = 8'd36;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] op_idx(input logic [2:0] f3);
		logic [4:0] r;
		case (f3)
			3'd0: r = 5'd0;
			3'd1: r = 5'd2;
			3'd2: r = 5'd3;
			3'd3: r = 5'd4;
			3'd4: r = 5'd5;
			3'd5: r = 5'd6;
			3'd6: r = 5'd8;
			default: r = 5'd9;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/rv64d_classify.sv -----
// Opcode classifier: maps a 32-bit word to operation code, immediate kind, target flag.
// Depends on rv64d_pkg.
`default_nettype none
module rv64d_classify import rv64d_pkg::*; (
	input  wire logic [31:0] word,
	output dec_ctl_t         ctl
);
	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [4:0] rs2;
	logic [4:0] f5;
	logic [4:0] idx;
	logic       idx_ok;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign f7  = word[31:25];
	assign rs2 = word[24:20];
	assign f5  = word[31:27];

	always_comb begin
		ctl = '{op_code: OP_UNKNOWN, imm_kind: IMM_NONE, has_target: 1'b0, ordering: 2'd0};
		idx = 5'd0;
		idx_ok = 1'b0;
		case (opc)
			OPC_LUI: begin
				ctl.op_code = OP_LUI; ctl.imm_kind = IMM_U;
			end
			OPC_AUIPC: begin
				ctl.op_code = OP_AUIPC; ctl.imm_kind = IMM_U;
			end
			OPC_JAL: begin
				ctl.op_code = OP_JAL; ctl.imm_kind = IMM_J; ctl.has_target = 1'b1;
			end
			OPC_JALR: begin
				ctl.op_code = OP_JALR; ctl.imm_kind = IMM_I;
			end
			OPC_BRANCH: begin
				if (f3 != 3'd2 && f3 != 3'd3) begin
					ctl.op_code = OP_BEQ + 8'((f3 < 3'd2) ? f3 : f3 - 3'd2);
					ctl.imm_kind = IMM_B; ctl.has_target = 1'b1;
				end
			end
			OPC_LOAD: begin
				if (f3 != 3'd7) begin
					ctl.op_code = OP_LB + 8'(f3); ctl.imm_kind = IMM_I;
				end
			end
			OPC_STORE: begin
				if (f3 < 3'd4) begin
					ctl.op_code = OP_SB + 8'(f3); ctl.imm_kind = IMM_S;
				end
			end
			OPC_AMO: begin
				if ((f5 == 5'd0 || f5 == 5'd2 || f5 == 5'd3) && (f3 == 3'd2 || f3 == 3'd3)) begin
					ctl.op_code = OP_AMOADD_W
						+ ((f5 == 5'd0) ? 8'd0 : (f5 == 5'd2) ? 8'd2 : 8'd4)
						+ ((f3 == 3'd3) ? 8'd1 : 8'd0);
					ctl.ordering = word[26:25];
				end
			end
			OPC_OPIMM: begin
				if (f3 == 3'd1 || f3 == 3'd5) begin
					ctl.imm_kind = IMM_SH6;
					ctl.op_code = (f3 == 3'd5 && word[30]) ? OP_SRAI : opimm_code(f3);
				end else begin
					ctl.imm_kind = IMM_I;
					ctl.op_code = opimm_code(f3);
				end
			end
			OPC_OPIMM32: begin
				if (f3 == 3'd0) begin
					ctl.op_code = OP_ADDIW; ctl.imm_kind = IMM_I;
				end else if (f3 == 3'd1) begin
					ctl.op_code = OP_SLLIW; ctl.imm_kind = IMM_SH5;
				end else if (f3 == 3'd5) begin
					ctl.op_code = (f7 == 7'h20) ? OP_SRAIW : OP_SRLIW;
					ctl.imm_kind = IMM_SH5;
				end
			end
			OPC_OP, OPC_OP32: begin
				if (f7 == 7'h01) idx = 5'd10 + 5'(f3);
				else if (f7 == 7'h20 && f3 == 3'd0) idx = 5'd1;
				else if (f7 == 7'h20 && f3 == 3'd5) idx = 5'd7;
				else idx = op_idx(f3);
				ctl.op_code = ((opc == OPC_OP32) ? OP_ADDW : OP_ADD) + 8'(idx);
			end
			OPC_FLOAD, OPC_FSTORE: begin
				if (f3 == 3'd2 || f3 == 3'd3) begin
					ctl.op_code = ((opc == OPC_FLOAD) ? OP_FLW : OP_FSW) + 8'(f3 - 3'd2);
					ctl.imm_kind = (opc == OPC_FLOAD) ? IMM_I : IMM_S;
				end
			end
			OPC_FP: begin
				case ({f7[6:1], 1'b0})
					7'h00: begin idx = 5'd0; idx_ok = 1'b1; end
					7'h04: begin idx = 5'd1; idx_ok = 1'b1; end
					7'h08: begin idx = 5'd2; idx_ok = 1'b1; end
					7'h0c: begin idx = 5'd3; idx_ok = 1'b1; end
					7'h2c: begin idx = 5'd4; idx_ok = 1'b1; end
					7'h10: begin
						idx = (f3 == 3'd0) ? 5'd5 : (f3 == 3'd1) ? 5'd6 : 5'd7;
						idx_ok = 1'b1;
					end
					7'h14: begin idx = (f3 == 3'd0) ? 5'd8 : 5'd9; idx_ok = 1'b1; end
					7'h50: begin
						idx = (f3 == 3'd2) ? 5'd10 : (f3 == 3'd1) ? 5'd11 : 5'd12;
						idx_ok = 1'b1;
					end
					7'h60: begin idx = 5'd13 + rs2; idx_ok = (rs2 < 5'd4); end
					7'h68: begin idx = 5'd17 + rs2; idx_ok = (rs2 < 5'd4); end
					7'h70: begin idx = 5'd21; idx_ok = (f3 == 3'd0); end
					7'h78: begin idx = 5'd22; idx_ok = (f3 == 3'd0); end
					7'h20: ctl.op_code = f7[0] ? OP_FCVT_D_S : OP_FCVT_S_D;
					default: ;
				endcase
				if (idx_ok)
					ctl.op_code = (f7[0] ? OP_FADD_D : OP_FADD_S) + 8'(idx);
			end
			OPC_SYSTEM: begin
				if (word == WORD_ECALL) ctl.op_code = OP_ECALL;
				else if (word == WORD_EBREAK) ctl.op_code = OP_EBREAK;
			end
			OPC_FENCE: ctl.op_code = OP_FENCE;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/rv64_instruction_decoder_top.sv -----
// Top level of the RV64 instruction decoder: four-stage pipeline with a global stall.
// Depends on rv64d_pkg and rv64d_classify.
//
// channel  dir  fields (tdata low bit up)
// s_axis   in   instr_word[31:0] pc[95:32] bytes_available[98:96]
// m_axis   out  decoded known op_code dest_reg src1_reg src2_reg immediate has_target
//               target ordering (bits 0..124)
//
// One word per cycle unless m_axis stalls; four register stages (capture, classify and
// immediate, target add, output) lie between s_axis and m_axis.
// The 64-bit target add sets the stage depth. Reset clears all valid bits.
// A stall holds every stage; s_axis_tready drops whenever the output word waits.
`default_nettype none
module rv64_instruction_decoder_top import rv64d_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // instr_word, pc, bytes_available
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [127:0] m_axis_tdata  // decoded, known, op_code, dest_reg, src1_reg,
	                                    // src2_reg, immediate, has_target, target, ordering
);
	logic        adv;
	logic        v_s1, v_s2, v_s3;
	logic [31:0] w_s1;
	logic [63:0] pc_s1, pc_s2;
	logic        dec_s1, dec_s2, dec_s3;
	dec_ctl_t    ctl_s2, ctl_s3;
	dec_ctl_t    ctl_c;
	logic [32:0] imm_c, imm_s2, imm_s3;
	logic [14:0] regs_s2, regs_s3;
	logic [63:0] tgt_s3;
	logic [124:0] res_c;

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	rv64d_classify u_cls (.word(w_s1), .ctl(ctl_c));

	always_comb begin
		case (ctl_c.imm_kind)
			IMM_I:   imm_c = 33'($signed(w_s1[31:20]));
			IMM_S:   imm_c = 33'($signed({w_s1[31:25], w_s1[11:7]}));
			IMM_B:   imm_c = 33'($signed({w_s1[31], w_s1[7], w_s1[30:25], w_s1[11:8], 1'b0}));
			IMM_J:   imm_c = 33'($signed({w_s1[31], w_s1[19:12], w_s1[20], w_s1[30:21], 1'b0}));
			IMM_U:   imm_c = {1'b0, w_s1[31:12], 12'd0};
			IMM_SH6: imm_c = {27'd0, w_s1[25:20]};
			IMM_SH5: imm_c = {28'd0, w_s1[24:20]};
			default: imm_c = 33'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			m_axis_tvalid <= v_s3;
		end
	end

	// stage 1: capture; stage 2: classify + immediate; stage 3: target; stage 4: output
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1   <= s_axis_tdata[31:0];
			pc_s1  <= s_axis_tdata[95:32];
			dec_s1 <= s_axis_tdata[98];
			pc_s2  <= pc_s1;
			dec_s2 <= dec_s1;
			ctl_s2 <= ctl_c;
			imm_s2 <= imm_c;
			regs_s2 <= {w_s1[24:20], w_s1[19:15], w_s1[11:7]};
			dec_s3 <= dec_s2;
			ctl_s3 <= ctl_s2;
			imm_s3 <= imm_s2;
			regs_s3 <= regs_s2;
			tgt_s3 <= ctl_s2.has_target ? pc_s2 + {{31{imm_s2[32]}}, imm_s2} : 64'd0;
			m_axis_tdata <= {3'd0, res_c};
		end
	end

	always_comb begin
		if (!dec_s3) res_c = '0;
		else res_c = {ctl_s3.ordering, tgt_s3, ctl_s3.has_target, imm_s3,
			regs_s3[14:10], regs_s3[9:5], regs_s3[4:0], ctl_s3.op_code,
			(ctl_s3.op_code != OP_UNKNOWN), 1'b1};
	end

`ifndef SYNTH
	a_unknown_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ctl_s3.op_code == OP_UNKNOWN) |-> (imm_s3 == 33'd0 && !ctl_s3.has_target))
		else $error("unknown op carries immediate or target");
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ctl_s3.has_target) |-> (tgt_s3 == 64'd0))
		else $error("target without has_target");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
		else $error("output changed under stall");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/rv64_instruction_decoder_top_test.sv -----
// Testbench for rv64_instruction_decoder_top: directed and random RV64 words with random
// stalls on both streams, checked field by field against an in-bench decode predictor.
// Depends on rv64d_pkg and the decoder RTL.
`timescale 1ns / 100ps
module rv64_instruction_decoder_top_test;
	import rv64d_pkg::*;

	localparam int N_RANDOM = 530;
	localparam int QUIET_FROM = 450;
	localparam logic [6:0] FP_SGNJ = 7'h10;
	localparam logic [6:0] FP_MINMAX = 7'h14;
	localparam logic [6:0] FP_CMP = 7'h50;
	localparam logic [6:0] FP_CVT_TO_INT = 7'h60;
	localparam logic [6:0] FP_CVT_FROM_INT = 7'h68;
	localparam logic [6:0] FP_MV_TO_INT = 7'h70;
	localparam logic [6:0] FP_MV_FROM_INT = 7'h78;
	localparam logic [6:0] FP_CVT_SD = 7'h20;
	localparam logic [6:0] FP_SQRT = 7'h2c;
	localparam logic [6:0] F7_ALT = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	typedef struct packed {
		logic [1:0]  ordering;
		logic [63:0] target;
		logic        has_target;
		logic [32:0] immediate;
		logic [4:0]  src2_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  dest_reg;
		logic [7:0]  op_code;
		logic        known;
		logic        decoded;
	} dec_word_t;

	function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
		logic [63:0] m;
		m = 64'd1 << (bits - 1);
		v = v & ((m << 1) - 64'd1);
		return (v ^ m) - m;
	endfunction

	function automatic dec_word_t decode_word(input logic [31:0] w, input logic [63:0] pc,
			input logic [2:0] avail);
		dec_word_t r;
		logic [6:0] opc, f7;
		logic [2:0] f3;
		logic [4:0] rs2, f5;
		logic [63:0] imm, imm_i, imm_s;
		logic [7:0] code;
		logic [7:0] opimm_tab [8];
		logic [7:0] op_tab [8];
		logic [7:0] base;
		int idx;
		opimm_tab = '{8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd35, 8'd36};
		op_tab = '{8'd0, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd9};
		r = '0;
		if (avail < 3'd4)
			return r;
		opc = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		rs2 = w[24:20];
		imm = '0;
		imm_i = sx({52'd0, w[31:20]}, 12);
		imm_s = sx({52'd0, w[31:25], w[11:7]}, 12);
		code = OP_UNKNOWN;
		case (opc)
			OPC_LUI: begin
				code = OP_LUI;
				imm = {32'd0, w[31:12], 12'd0};
			end
			OPC_AUIPC: begin
				code = OP_AUIPC;
				imm = {32'd0, w[31:12], 12'd0};
			end
			OPC_JAL: begin
				code = OP_JAL;
				imm = sx({43'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
				r.has_target = 1'b1;
			end
			OPC_JALR: begin
				code = OP_JALR;
				imm = imm_i;
			end
			OPC_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) begin
				code = OP_BEQ + (f3 < 3'd2 ? f3 : f3 - 3'd2);
				imm = sx({51'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
				r.has_target = 1'b1;
			end
			OPC_LOAD: if (f3 != 3'd7) begin
				code = OP_LB + f3;
				imm = imm_i;
			end
			OPC_STORE: if (f3 < 3'd4) begin
				code = OP_SB + f3;
				imm = imm_s;
			end
			OPC_AMO: begin
				f5 = w[31:27];
				idx = f5 == 5'd0 ? 0 : (f5 == 5'd2 ? 1 : (f5 == 5'd3 ? 2 : 3));
				if (idx < 3 && (f3 == 3'd2 || f3 == 3'd3)) begin
					code = OP_AMOADD_W + 2 * idx + (f3 == 3'd3);
					r.ordering = w[26:25];
				end
			end
			OPC_OPIMM: if (f3 == 3'd1 || f3 == 3'd5) begin
				imm = {58'd0, w[25:20]};
				code = (f3 == 3'd5 && w[30]) ? OP_SRAI : opimm_tab[f3];
			end else begin
				code = opimm_tab[f3];
				imm = imm_i;
			end
			OPC_OPIMM32: if (f3 == 3'd0) begin
				code = OP_ADDIW;
				imm = imm_i;
			end else if (f3 == 3'd1) begin
				code = OP_SLLIW;
				imm = {59'd0, w[24:20]};
			end else if (f3 == 3'd5) begin
				code = f7 == F7_ALT ? OP_SRAIW : OP_SRLIW;
				imm = {59'd0, w[24:20]};
			end
			OPC_OP, OPC_OP32: begin
				if (f7 == F7_MULDIV)
					idx = 10 + f3;
				else if (f7 == F7_ALT && f3 == 3'd0)
					idx = 1;
				else if (f7 == F7_ALT && f3 == 3'd5)
					idx = 7;
				else
					idx = op_tab[f3];
				code = (opc == OPC_OP32 ? OP_ADDW : OP_ADD) + idx;
			end
			OPC_FLOAD: if (f3 == 3'd2 || f3 == 3'd3) begin
				code = OP_FLW + (f3 - 3'd2);
				imm = imm_i;
			end
			OPC_FSTORE: if (f3 == 3'd2 || f3 == 3'd3) begin
				code = OP_FSW + (f3 - 3'd2);
				imm = imm_s;
			end
			OPC_FP: begin
				base = f7[0] ? OP_FADD_D : OP_FADD_S;
				idx = -1;
				case (f7 & 7'h7e)
					7'h00: idx = 0;
					7'h04: idx = 1;
					7'h08: idx = 2;
					7'h0c: idx = 3;
					FP_SQRT: idx = 4;
					FP_SGNJ: idx = f3 == 3'd0 ? 5 : (f3 == 3'd1 ? 6 : 7);
					FP_MINMAX: idx = f3 == 3'd0 ? 8 : 9;
					FP_CMP: idx = f3 == 3'd2 ? 10 : (f3 == 3'd1 ? 11 : 12);
					FP_CVT_TO_INT: if (rs2 < 5'd4) idx = 13 + rs2;
					FP_CVT_FROM_INT: if (rs2 < 5'd4) idx = 17 + rs2;
					FP_MV_TO_INT: if (f3 == 3'd0) idx = 21;
					FP_MV_FROM_INT: if (f3 == 3'd0) idx = 22;
					FP_CVT_SD: code = f7[0] ? OP_FCVT_D_S : OP_FCVT_S_D;
					default: ;
				endcase
				if (idx >= 0)
					code = base + idx;
			end
			OPC_SYSTEM: if (w == WORD_ECALL) begin
				code = OP_ECALL;
			end else if (w == WORD_EBREAK) begin
				code = OP_EBREAK;
			end
			OPC_FENCE: code = OP_FENCE;
			default: ;
		endcase
		if (code == OP_UNKNOWN) begin
			imm = '0;
			r.has_target = 1'b0;
			r.ordering = '0;
		end
		r.decoded = 1'b1;
		r.known = code != OP_UNKNOWN;
		r.op_code = code;
		r.dest_reg = w[11:7];
		r.src1_reg = w[19:15];
		r.src2_reg = rs2;
		r.immediate = imm[32:0];
		r.target = r.has_target ? pc + imm : 64'd0;
		return r;
	endfunction

	class decode_scoreboard;
		dec_word_t expected_q[$];
		int errors;

		function void note_word(input logic [31:0] w, input logic [63:0] pc,
				input logic [2:0] avail);
			expected_q.push_back(decode_word(w, pc, avail));
		endfunction

		function void cmp(input string name, input logic [63:0] e, input logic [63:0] a);
			if (e !== a) begin
				$error("%s: expected %h, got %h", name, e, a);
				errors++;
			end
		endfunction

		function void check_word(input logic [127:0] d);
			dec_word_t e, a;
			a = d[124:0];
			if (expected_q.size() == 0) begin
				$error("unexpected output word %h", d);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("decoded", e.decoded, a.decoded);
			cmp("known", e.known, a.known);
			cmp("op_code", e.op_code, a.op_code);
			cmp("dest_reg", e.dest_reg, a.dest_reg);
			cmp("src1_reg", e.src1_reg, a.src1_reg);
			cmp("src2_reg", e.src2_reg, a.src2_reg);
			cmp("immediate", e.immediate, a.immediate);
			cmp("has_target", e.has_target, a.has_target);
			cmp("target", e.target, a.target);
			cmp("ordering", e.ordering, a.ordering);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [103:0] s_axis_tdata = '0;  // instr_word, pc, bytes_available
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;  // decoded, known, op_code, dest_reg, src1_reg, src2_reg,
	                              // immediate, has_target, target, ordering
	decode_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_done = 1'b0;
	bit hold_req = 1'b0;

	rv64_instruction_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	task automatic send_word(input logic [31:0] w, input logic [63:0] pc,
			input logic [2:0] avail);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, avail, pc, w};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_word(w, pc, avail);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rand_pc();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rand_word();
		logic [6:0] opcs [17];
		logic [6:0] fp_f7 [14];
		logic [31:0] w;
		opcs = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
			OPC_AMO, OPC_OPIMM, OPC_OPIMM32, OPC_OP, OPC_OP32, OPC_FLOAD, OPC_FSTORE,
			OPC_FP, OPC_SYSTEM, OPC_FENCE};
		fp_f7 = '{7'h00, 7'h04, 7'h08, 7'h0c, FP_SQRT, FP_SGNJ, FP_MINMAX, FP_CMP,
			FP_CVT_TO_INT, FP_CVT_FROM_INT, FP_MV_TO_INT, FP_MV_FROM_INT, FP_CVT_SD, 7'h7e};
		w = $urandom;
		if ($urandom_range(0, 9) == 0)
			return w;
		w[6:0] = opcs[$urandom_range(0, 16)];
		case (w[6:0])
			OPC_AMO: if ($urandom_range(0, 3) != 0) begin
				w[14:12] = $urandom_range(2, 3);
				w[31:27] = $urandom_range(0, 1) ? 5'd0 : $urandom_range(2, 3);
			end
			OPC_OP, OPC_OP32: if ($urandom_range(0, 3) != 0)
				w[31:25] = $urandom_range(0, 1) ? F7_MULDIV : ($urandom_range(0, 1) ? F7_ALT : 7'h00);
			OPC_FP: if ($urandom_range(0, 3) != 0) begin
				w[31:25] = fp_f7[$urandom_range(0, 13)] | $urandom_range(0, 1);
				if ($urandom_range(0, 1))
					w[24:20] = $urandom_range(0, 4);
				if ($urandom_range(0, 1))
					w[14:12] = $urandom_range(0, 2);
			end
			OPC_SYSTEM: case ($urandom_range(0, 2))
				0: w = WORD_ECALL;
				1: w = WORD_EBREAK;
				default: ;
			endcase
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		logic [31:0] dir_words [$];
		logic [2:0] avail;
		dir_words = '{WORD_ECALL, WORD_EBREAK, 32'hfffff037, 32'h00000017, 32'h800000ef,
			32'h7ffff0ef, 32'hfe000fe3, 32'h7e007f63, 32'h40005013, 32'h0000501b,
			32'h4000501b, 32'h7e0000b3, 32'h0200703b, 32'hfff53003, 32'hfe0fbfa3,
			32'h0600a2af, 32'h1000b02f, 32'h1800202f, 32'h22007053, 32'h4010f053,
			32'hd030f0d3, 32'hf0000053, 32'hfff0f00f, 32'h00000000, 32'hffffffff};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_word(32'h00000013, 64'h0, 3'd0);
		send_word(32'h00000013, 64'h0, 3'd3);
		send_word(32'h00000013, 64'hffffffffffffffff, 3'd5);
		send_word(32'h00000013, 64'h0, 3'd7);
		foreach (dir_words[i])
			send_word(dir_words[i], i[0] ? 64'hfffffffffffffffc : 64'h0, 3'd4);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 100)
				hold_req = 1'b1;
			if (i == QUIET_FROM)
				quiet = 1'b1;
			avail = $urandom_range(0, 7) == 0 ? 3'($urandom_range(0, 7)) : 3'd4;
			send_word(rand_word(), rand_pc(), avail);
		end
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("[rv64_instruction_decoder_top] OK");
		else
			$display("[rv64_instruction_decoder_top] ERROR");
		$finish;
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall = 60;
			end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[rv64_instruction_decoder_top] ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/rv64d_pkg.sv
hdl/rv64d_classify.sv
hdl/rv64_instruction_decoder_top.sv
tb/sv/rv64_instruction_decoder_top_test.sv
